[hw/rtl/display_list_validator_top_defines.svh]
// ----------------------------------------------------------------------------
// Display list validator assertion macros
// Shared property macros for the checker of the display list validator.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LIST_VALIDATOR_TOP_DEFINES_SVH
`define DISPLAY_LIST_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DLV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DLV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dlv_pkg.sv]
// ----------------------------------------------------------------------------
// Display list validator package
// Limits, codes, shared types and float helpers of the validator.
// ----------------------------------------------------------------------------
package dlv_pkg;

	localparam logic [31:0] MaxOps       = 32'd4096;
	localparam logic [31:0] MaxPoints    = 32'd16384;
	localparam logic [31:0] MaxTextBytes = 32'd65536;
	localparam logic [31:0] MaxImages    = 32'd256;

	localparam int unsigned DepthW = 13;
	localparam logic [DepthW-1:0] DepthMax = '1;

	localparam logic [31:0] MinPolyPoints = 32'd2;

	typedef enum logic [2:0] {
		OP_TEXT      = 3'd0,
		OP_POLYLINE  = 3'd1,
		OP_IMAGE     = 3'd2,
		OP_CLIP_PUSH = 3'd3,
		OP_CLIP_POP  = 3'd4,
		OP_RECT      = 3'd5,
		OP_LINE      = 3'd6
	} opcode_t;

	typedef enum logic [3:0] {
		ST_OK              = 4'd0,
		ST_LIST_VALID      = 4'd1,
		ST_TOO_MANY_OPS    = 4'd2,
		ST_TEXT_TOO_BIG    = 4'd3,
		ST_TOO_MANY_POINTS = 4'd4,
		ST_TOO_MANY_IMAGES = 4'd5,
		ST_BAD_CONTENT     = 4'd6,
		ST_NONFINITE_RECT  = 4'd7,
		ST_TEXT_RANGE      = 4'd8,
		ST_POLY_SHORT      = 4'd9,
		ST_POINT_RANGE     = 4'd10,
		ST_UNKNOWN_IMAGE   = 4'd11,
		ST_UNBALANCED_POP  = 4'd12,
		ST_UNBALANCED_PUSH = 4'd13
	} status_t;

	typedef enum logic [2:0] {
		REG_OP_COUNT      = 3'd0,
		REG_TEXT_SIZE     = 3'd1,
		REG_POINT_COUNT   = 3'd2,
		REG_IMAGE_COUNT   = 3'd3,
		REG_CONTENT_W     = 3'd4,
		REG_CONTENT_H     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [31:0] op_count;
		logic [31:0] text_size;
		logic [31:0] point_count;
		logic [31:0] image_count;
		logic [31:0] content_width_bits;
		logic [31:0] content_height_bits;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] rect_x;
		logic [31:0] rect_y;
		logic [31:0] rect_w;
		logic [31:0] rect_h;
		logic [31:0] slice_offset;
		logic [31:0] slice_count;
		logic        last_op;
	} item_t;

	// An all-ones exponent means infinity or NaN.
	function automatic logic is_nonfinite(input logic [31:0] bits);
		return bits[30:23] == 8'hFF;
	endfunction

	// Negative zero is allowed; any other value with the sign set is not.
	function automatic logic bad_dimension(input logic [31:0] bits);
		return is_nonfinite(bits) || (bits[31] && (bits[30:0] != 31'd0));
	endfunction

endpackage

[hw/rtl/dlv_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Display list validator configuration registers
// Holds the six list size and content size registers.
// ----------------------------------------------------------------------------
module dlv_cfg_regs
	import dlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			// Indexes past the last register are dropped.
			unique case (cfg_index)
				REG_OP_COUNT:    cfg_q.op_count            <= cfg_data;
				REG_TEXT_SIZE:   cfg_q.text_size           <= cfg_data;
				REG_POINT_COUNT: cfg_q.point_count         <= cfg_data;
				REG_IMAGE_COUNT: cfg_q.image_count         <= cfg_data;
				REG_CONTENT_W:   cfg_q.content_width_bits  <= cfg_data;
				REG_CONTENT_H:   cfg_q.content_height_bits <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/dlv_check.sv]
// ----------------------------------------------------------------------------
// Display list validator check stage
// Per-op checks, clip depth tracking and first-error latch of a list.
// ----------------------------------------------------------------------------
module dlv_check
	import dlv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    advance,
	output status_t result
);

	logic [DepthW-1:0] clip_depth_q;
	status_t           latched_error_q;

	status_t           list_err;
	status_t           op_err;
	status_t           err;
	logic [32:0]       slice_end;
	logic              rect_bad;
	logic [DepthW-1:0] depth_next;
	logic [DepthW-1:0] depth_op;

	assign slice_end = {1'b0, item.slice_offset} + {1'b0, item.slice_count};
	assign rect_bad  = is_nonfinite(item.rect_x) || is_nonfinite(item.rect_y) ||
		is_nonfinite(item.rect_w) || is_nonfinite(item.rect_h);

	always_comb begin
		if (cfg.op_count > MaxOps) begin
			list_err = ST_TOO_MANY_OPS;
		end else if (cfg.point_count > MaxPoints) begin
			list_err = ST_TOO_MANY_POINTS;
		end else if (cfg.text_size > MaxTextBytes) begin
			list_err = ST_TEXT_TOO_BIG;
		end else if (cfg.image_count > MaxImages) begin
			list_err = ST_TOO_MANY_IMAGES;
		end else if (bad_dimension(cfg.content_width_bits) ||
				bad_dimension(cfg.content_height_bits)) begin
			list_err = ST_BAD_CONTENT;
		end else begin
			list_err = ST_OK;
		end
	end

	always_comb begin
		op_err   = ST_OK;
		depth_op = clip_depth_q;
		if (rect_bad) begin
			op_err = ST_NONFINITE_RECT;
		end else begin
			case (item.opcode)
				OP_TEXT: begin
					if (slice_end > {1'b0, cfg.text_size}) op_err = ST_TEXT_RANGE;
				end
				OP_POLYLINE: begin
					if (item.slice_count < MinPolyPoints) begin
						op_err = ST_POLY_SHORT;
					end else if (slice_end > {1'b0, cfg.point_count}) begin
						op_err = ST_POINT_RANGE;
					end
				end
				OP_IMAGE: begin
					if (item.slice_offset >= cfg.image_count) op_err = ST_UNKNOWN_IMAGE;
				end
				OP_CLIP_PUSH: begin
					// The depth saturates rather than wrapping.
					if (clip_depth_q != DepthMax) depth_op = clip_depth_q + 1'b1;
				end
				OP_CLIP_POP: begin
					if (clip_depth_q == '0) begin
						op_err = ST_UNBALANCED_POP;
					end else begin
						depth_op = clip_depth_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		depth_next = clip_depth_q;
		if (latched_error_q != ST_OK) begin
			err = latched_error_q;
		end else if (list_err != ST_OK) begin
			err = list_err;
		end else begin
			err        = op_err;
			depth_next = depth_op;
		end

		result = err;
		if (item.last_op && err == ST_OK) begin
			result = (depth_next != '0) ? ST_UNBALANCED_PUSH : ST_LIST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_depth_q    <= '0;
			latched_error_q <= ST_OK;
		end else if (advance) begin
			if (item.last_op) begin
				clip_depth_q    <= '0;
				latched_error_q <= ST_OK;
			end else begin
				clip_depth_q    <= depth_next;
				latched_error_q <= err;
			end
		end
	end

endmodule

[hw/rtl/display_list_validator_top.sv]
// ----------------------------------------------------------------------------
// Display list validator
// Checks a stream of draw ops against the configured list and content sizes.
// ----------------------------------------------------------------------------
// One op enters per clock cycle while the output does not stall, and every op
// yields exactly one result. An accepted op is held in the input register and
// checked there by compare logic against the configuration registers and the
// clip depth; its status goes to the result register that drives the output.
// The input side keeps taking ops while a result waits, as long as the input
// register is empty or the result register can move on in the same cycle.
// The first error of a list is held and repeated until the op marked last,
// which reports the verdict and clears the clip depth and the error for the
// next list. Configuration writes are registered and always taken.
// ----------------------------------------------------------------------------
module display_list_validator_top
	import dlv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] rect_x,
	input  logic [31:0] rect_y,
	input  logic [31:0] rect_w,
	input  logic [31:0] rect_h,
	input  logic [31:0] slice_offset,
	input  logic [31:0] slice_count,
	input  logic        last_op,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        list_done
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	status_t status_s2;
	logic    list_done_s2;
	status_t check_status;
	logic    advance;

	dlv_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{opcode: opcode, rect_x: rect_x, rect_y: rect_y,
				rect_w: rect_w, rect_h: rect_h, slice_offset: slice_offset,
				slice_count: slice_count, last_op: last_op};
		end
	end

	dlv_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (check_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2    <= check_status;
			list_done_s2 <= item_s1.last_op;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign list_done = list_done_s2;

endmodule

[hw/rtl/dlv_checker.sv]
// ----------------------------------------------------------------------------
// Display list validator checker
// Port-level assertions on the validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "display_list_validator_top_defines.svh"

module dlv_port_checker
	import dlv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] status,
	input logic       list_done
);

	// A stalled result must hold until its transaction completes.
	`DLV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(list_done), "stalled result changed")

	// With the result register empty, nothing can block the input side.
	`DLV_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input stalled with no result pending")

	// A closed list always carries a verdict, never the running status.
	`DLV_ASSERT_NOW(a_close_verdict, out_valid && list_done,
		status != ST_OK, "closing result reports ok so far")

	// The list verdicts appear only on the result that closes the list.
	`DLV_ASSERT_NOW(a_verdict_close, out_valid && !list_done,
		status != ST_LIST_VALID && status != ST_UNBALANCED_PUSH,
		"list verdict on an open list")

endmodule

bind display_list_validator_top dlv_port_checker u_dlv_checker (.*);
